@@ rtl/core/box_min_area_overlap_match_defines.svh @@
// Assertion macros shared by the overlap matcher RTL.
`ifndef BOX_MIN_AREA_OVERLAP_MATCH_DEFINES_SVH
`define BOX_MIN_AREA_OVERLAP_MATCH_DEFINES_SVH

// Implication checked every clock, off while reset is asserted.
`define BMAO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check with no reset qualifier.
`define BMAO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bmao_pkg.sv @@
// Shared constants, codes and control types of the overlap matcher.
`default_nettype none
package bmao_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int COORD_W = 32;
    localparam int AREA_W  = 64;
    localparam int PAGE_W  = 15;
    localparam int THR_W   = 17;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [COORD_W-1:0] ONE_Q16 = 32'd65536;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

    localparam logic [PAGE_W-1:0] PAGE_RESET = 15'd1;
    localparam logic [THR_W-1:0]  THR_RESET  = 17'd32768;

    typedef struct packed {
        logic             capture;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             result;
    } t_cmd;

    typedef struct packed {
        logic box_ok;
        logic pipe_busy;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/core/bmao_ctrl.sv @@
// Sequencer: request handshake, table count, scan addressing and result hand-off.
`default_nettype none
`include "box_min_area_overlap_match_defines.svh"
module bmao_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [bmao_pkg::OP_W-1:0] i_operation,
    input  wire logic                      i_ready,
    input  wire bmao_pkg::t_status         i_status,
    output logic                           o_ready,
    output logic                           o_valid,
    output bmao_pkg::t_cmd                 o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ORDER,
        ST_AREA,
        ST_STORE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state                         r_state, n_state;
    logic [bmao_pkg::OP_W-1:0]      r_op, n_op;
    logic [bmao_pkg::CNT_W-1:0]     r_count, n_count;
    logic [bmao_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic                           r_out_valid, n_out_valid;
    bmao_pkg::t_cmd                 cmd;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        cmd         = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_op        = i_operation;
                    if (i_operation == bmao_pkg::OP_CLEAR) begin
                        n_count = '0;
                    end else if (i_operation inside {bmao_pkg::OP_LOAD,
                                                     bmao_pkg::OP_QUERY}) begin
                        n_state = ST_SCALE;
                    end
                end
            end
            ST_SCALE: n_state = ST_ORDER;
            ST_ORDER: n_state = ST_AREA;
            ST_AREA: begin
                if (r_op == bmao_pkg::OP_LOAD) begin
                    if (i_status.box_ok &&
                        (r_count < bmao_pkg::CNT_W'(bmao_pkg::TABLE_DEPTH))) begin
                        n_state = ST_STORE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (!i_status.box_ok || (r_count == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_STORE: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = r_count[bmao_pkg::IDX_W-1:0];
                n_count     = r_count + 1'b1;
                n_state     = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = r_idx;
                n_idx       = r_idx + 1'b1;
                if ((bmao_pkg::CNT_W'(r_idx) + bmao_pkg::CNT_W'(1)) == r_count) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    cmd.result  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= bmao_pkg::OP_LOAD;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    `BMAO_ASSERT(a_idle_pipe_empty, i_clk, i_rst_n, (r_state == ST_IDLE) |-> !i_status.pipe_busy, "request taken while scan pipeline busy")
    `BMAO_ASSERT(a_store_has_room, i_clk, i_rst_n, cmd.wr_en |-> (r_count < bmao_pkg::CNT_W'(bmao_pkg::TABLE_DEPTH)), "store past table capacity")
    `BMAO_ASSERT(a_read_below_count, i_clk, i_rst_n, cmd.rd_en |-> (bmao_pkg::CNT_W'(cmd.rd_addr) < r_count), "scan reads an unfilled entry")
    `BMAO_ASSERT_ALWAYS(a_count_bounded, i_clk, !i_rst_n || (r_count <= bmao_pkg::CNT_W'(bmao_pkg::TABLE_DEPTH)), "table count above depth")

endmodule
`default_nettype wire

@@ rtl/core/bmao_dp.sv @@
// Datapath: box normalization, reference table memories and overlap test pipeline.
`default_nettype none
module bmao_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bmao_pkg::t_cmd                  i_cmd,
    input  wire logic signed [bmao_pkg::COORD_W-1:0] i_corner_x0,
    input  wire logic signed [bmao_pkg::COORD_W-1:0] i_corner_y0,
    input  wire logic signed [bmao_pkg::COORD_W-1:0] i_corner_x1,
    input  wire logic signed [bmao_pkg::COORD_W-1:0] i_corner_y1,
    input  wire logic [bmao_pkg::PAGE_W-1:0]     i_page_width,
    input  wire logic [bmao_pkg::PAGE_W-1:0]     i_page_height,
    input  wire logic [bmao_pkg::THR_W-1:0]      i_threshold,
    output bmao_pkg::t_status                    o_status,
    output logic                                 o_box_valid,
    output logic                                 o_is_match
);

    localparam int CW   = bmao_pkg::COORD_W;
    localparam int AW   = bmao_pkg::AREA_W;
    localparam int PW   = bmao_pkg::PAGE_W;
    localparam int TW   = bmao_pkg::THR_W;
    localparam int PPW  = TW + CW;          // partial product width
    localparam int RHSW = TW + AW;          // threshold times area
    localparam int FRAC = 16;

    // scale a normalized coordinate by a page size
    function automatic logic signed [CW-1:0] scale_coord(
        input logic signed [CW-1:0] c,
        input logic                 unit,
        input logic [PW-1:0]        pg
    );
        logic [CW-1:0] prod;
        prod = {{(CW-FRAC-1){1'b0}}, c[FRAC:0]} * {{(CW-PW){1'b0}}, pg};
        return unit ? $signed(prod) : c;
    endfunction

    function automatic logic in_unit(input logic signed [CW-1:0] c);
        return (c >= 0) && (c <= $signed(bmao_pkg::ONE_Q16));
    endfunction

    // captured request coordinates
    logic signed [CW-1:0] r_cx0, r_cy0, r_cx1, r_cy1;
    // scaled corners
    logic signed [CW-1:0] r_sx0, r_sy0, r_sx1, r_sy1;
    // ordered box
    logic signed [CW-1:0] r_l, r_t, r_r, r_b;
    logic                 r_box_ok;
    logic [AW-1:0]        r_qa;

    logic                 unit_all;
    logic [CW-1:0]        qw, qh;

    // table
    logic [4*CW-1:0]      r_mem_box  [bmao_pkg::TABLE_DEPTH];
    logic [AW-1:0]        r_mem_area [bmao_pkg::TABLE_DEPTH];
    logic [4*CW-1:0]      r_rd_box;
    logic [AW-1:0]        r_rd_area;

    // scan pipeline
    logic [3:0]           r_pv;
    logic [CW-1:0]        r_iw, r_ih;
    logic [AW-1:0]        r_p1_area;
    logic [AW-1:0]        r_inter, r_min;
    logic [AW-1:0]        r_lhs;
    logic [PPW-1:0]       r_plo, r_phi;
    logic                 r_hit;
    logic                 r_out_box_valid, r_out_match;

    logic signed [CW-1:0] rl, rt, rr, rb;
    logic signed [CW-1:0] il, it, ir, ib;
    logic [CW-1:0]        iw, ih;
    logic                 overlap;
    logic [RHSW-1:0]      rhs;
    logic [RHSW-1:0]      lhs;
    logic                 hit;

    assign unit_all = in_unit(r_cx0) && in_unit(r_cy0) && in_unit(r_cx1) && in_unit(r_cy1);
    assign qw = r_r - r_l;
    assign qh = r_b - r_t;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cx0 <= i_corner_x0;
            r_cy0 <= i_corner_y0;
            r_cx1 <= i_corner_x1;
            r_cy1 <= i_corner_y1;
        end
        r_sx0    <= scale_coord(r_cx0, unit_all, i_page_width);
        r_sx1    <= scale_coord(r_cx1, unit_all, i_page_width);
        r_sy0    <= scale_coord(r_cy0, unit_all, i_page_height);
        r_sy1    <= scale_coord(r_cy1, unit_all, i_page_height);
        r_l      <= (r_sx1 < r_sx0) ? r_sx1 : r_sx0;
        r_r      <= (r_sx1 < r_sx0) ? r_sx0 : r_sx1;
        r_t      <= (r_sy1 < r_sy0) ? r_sy1 : r_sy0;
        r_b      <= (r_sy1 < r_sy0) ? r_sy0 : r_sy1;
        r_box_ok <= (r_sx0 != r_sx1) && (r_sy0 != r_sy1);
        r_qa     <= {{(AW-CW){1'b0}}, qw} * {{(AW-CW){1'b0}}, qh};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem_box[i_cmd.wr_addr]  <= {r_l, r_t, r_r, r_b};
            r_mem_area[i_cmd.wr_addr] <= r_qa;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_box  <= r_mem_box[i_cmd.rd_addr];
        r_rd_area <= r_mem_area[i_cmd.rd_addr];
    end

    assign rl = $signed(r_rd_box[4*CW-1:3*CW]);
    assign rt = $signed(r_rd_box[3*CW-1:2*CW]);
    assign rr = $signed(r_rd_box[2*CW-1:CW]);
    assign rb = $signed(r_rd_box[CW-1:0]);

    assign il = (rl > r_l) ? rl : r_l;
    assign it = (rt > r_t) ? rt : r_t;
    assign ir = (rr < r_r) ? rr : r_r;
    assign ib = (rb < r_b) ? rb : r_b;
    assign overlap = (ir > il) && (ib > it);
    assign iw = ir - il;
    assign ih = ib - it;

    assign rhs = {{(RHSW-PPW){1'b0}}, r_plo} + {r_phi[RHSW-CW-1:0], {CW{1'b0}}};
    assign lhs = {{(RHSW-AW-FRAC){1'b0}}, r_lhs, {FRAC{1'b0}}};
    assign hit = (lhs >= rhs);

    always_ff @(posedge i_clk) begin
        r_iw      <= overlap ? iw : '0;
        r_ih      <= overlap ? ih : '0;
        r_p1_area <= r_rd_area;
        r_inter   <= {{(AW-CW){1'b0}}, r_iw} * {{(AW-CW){1'b0}}, r_ih};
        r_min     <= (r_p1_area < r_qa) ? r_p1_area : r_qa;
        r_plo     <= {{CW{1'b0}}, i_threshold} * {{TW{1'b0}}, r_min[CW-1:0]};
        r_phi     <= {{CW{1'b0}}, i_threshold} * {{TW{1'b0}}, r_min[AW-1:CW]};
        r_lhs     <= r_inter;
        if (i_cmd.result) begin
            r_out_box_valid <= r_box_ok;
            r_out_match     <= r_box_ok && r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= '0;
            r_hit <= 1'b0;
        end else begin
            r_pv <= {r_pv[2:0], i_cmd.rd_en};
            if (i_cmd.capture) begin
                r_hit <= 1'b0;
            end else if (r_pv[3] && hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_status.box_ok    = r_box_ok;
    assign o_status.pipe_busy = |r_pv;
    assign o_box_valid        = r_out_box_valid;
    assign o_is_match         = r_out_match;

endmodule
`default_nettype wire

@@ rtl/core/box_min_area_overlap_match.sv @@
// Top level of the reference box overlap matcher with its configuration registers.
`default_nettype none
// Stores up to 16 reference boxes and answers query boxes with a valid flag and a
// match flag (intersection over smaller area at or above the threshold). One request
// is processed at a time. A load goes through the scale, order and area steps and is
// stored unless the box is invalid or the table is full; a clear or an unused code is
// taken in the idle state. A query with N stored boxes scans all of them: the comparison
// pipeline reads one stored box per cycle from the table memory and is drained before
// the result is presented. An invalid query or an empty table skips the scan.
// A finished result waits in the output register while the next request is taken;
// the next result waits until that one is accepted.
module box_min_area_overlap_match (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bmao_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bmao_pkg::THR_W-1:0]           i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [bmao_pkg::OP_W-1:0]            i_operation,
    input  wire logic signed [bmao_pkg::COORD_W-1:0]  i_corner_x0,
    input  wire logic signed [bmao_pkg::COORD_W-1:0]  i_corner_y0,
    input  wire logic signed [bmao_pkg::COORD_W-1:0]  i_corner_x1,
    input  wire logic signed [bmao_pkg::COORD_W-1:0]  i_corner_y1,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic                                      o_box_valid,
    output logic                                      o_is_match
);

    logic [bmao_pkg::PAGE_W-1:0] r_page_width, r_page_height;
    logic [bmao_pkg::THR_W-1:0]  r_threshold;
    bmao_pkg::t_cmd              cmd;
    bmao_pkg::t_status           status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_width  <= bmao_pkg::PAGE_RESET;
            r_page_height <= bmao_pkg::PAGE_RESET;
            r_threshold   <= bmao_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmao_pkg::CFG_PAGE_WIDTH:  r_page_width  <= i_cfg_data[bmao_pkg::PAGE_W-1:0];
                bmao_pkg::CFG_PAGE_HEIGHT: r_page_height <= i_cfg_data[bmao_pkg::PAGE_W-1:0];
                bmao_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bmao_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_ready     (i_ready),
        .i_status    (status),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .o_cmd       (cmd)
    );

    bmao_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_corner_x0   (i_corner_x0),
        .i_corner_y0   (i_corner_y0),
        .i_corner_x1   (i_corner_x1),
        .i_corner_y1   (i_corner_y1),
        .i_page_width  (r_page_width),
        .i_page_height (r_page_height),
        .i_threshold   (r_threshold),
        .o_status      (status),
        .o_box_valid   (o_box_valid),
        .o_is_match    (o_is_match)
    );

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the box overlap matcher: a directed table, then random traffic.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmao_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 80;
    localparam int N_PHASES     = 8;
    localparam int DIR_ROWS     = 19;

    typedef struct {
        longint lo_x;
        longint lo_y;
        longint hi_x;
        longint hi_y;
    } t_box;

    typedef struct packed {
        logic box_valid;
        logic is_match;
    } t_answer;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic               pin;
        logic               pin_valid;
        logic               pin_match;
    } t_row;

    typedef enum int {K_GRID, K_UNIT, K_FULL, K_EDGE} t_coord_kind;

    // pin set: the answer is typed in here and used instead of the predicted one
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{OP_QUERY, 32'h0000_0000, 32'h0000_0000, ONE_Q16, ONE_Q16, 1'b1, 1'b1, 1'b0},
        '{OP_QUERY, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0009,
          1'b1, 1'b0, 1'b0},
        '{OP_QUERY, 32'h000A_0000, 32'h000A_0000, 32'h0002_0000, 32'h0002_0000,
          1'b1, 1'b1, 1'b0},
        '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 1'b0, 1'b0},
        '{OP_LOAD, 32'h0002_0000, 32'h0002_0000, 32'h000A_0000, 32'h000A_0000,
          1'b0, 1'b0, 1'b0},
        '{OP_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, ONE_Q16, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0004_0000, 32'h0004_0000, 32'h0006_0000, 32'h0006_0000,
          1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0064_0000, 32'h0064_0000, 32'h00C8_0000, 32'h00C8_0000,
          1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0009_0000, 32'h0009_0000, 32'h000B_0000, 32'h000B_0000,
          1'b0, 1'b0, 1'b0},
        '{OP_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001,
          1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0000_0000, 32'h0000_0000, ONE_Q16, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'hF0F0_0F0F,
          1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b1, 1'b1, 1'b0},
        '{OP_LOAD, ONE_Q16, ONE_Q16, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0000_8000, 32'h0000_8000, 32'h0001_8000, 32'h0001_8000,
          1'b0, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0000_0000, 32'h0000_0000, 32'h0000_8000, ONE_Q16, 1'b0, 1'b0, 1'b0}
    };

    localparam logic [COORD_W-1:0] EDGE_VALUES [8] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001,
        32'h0001_0000, 32'h0001_0001, 32'hFFFF_FFFF, 32'h0000_FFFF
    };

    // -1 picks a random value when the phase starts
    localparam int PH_WIDTH  [N_PHASES] = '{64, 0, 32767, 1, -1, 50, -1, 64};
    localparam int PH_HEIGHT [N_PHASES] = '{64, 32767, 32767, 1, -1, 0, -1, 48};
    localparam int PH_THR    [N_PHASES] = '{32768, 0, 65536, -1, -1, 1, -1, 49152};
    localparam int PH_SEND   [N_PHASES] = '{0, 70, 0, 6, 0, 70, 0, 6};
    localparam int PH_STALL  [N_PHASES] = '{0, 0, 70, 6, 0, 0, 70, 6};

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [THR_W-1:0]          i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [OP_W-1:0]           i_operation = OP_LOAD;
    logic signed [COORD_W-1:0] i_corner_x0 = '0;
    logic signed [COORD_W-1:0] i_corner_y0 = '0;
    logic signed [COORD_W-1:0] i_corner_x1 = '0;
    logic signed [COORD_W-1:0] i_corner_y1 = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_box_valid;
    logic                      o_is_match;

    logic pin_row = 1'b0;
    logic pin_valid = 1'b0;
    logic pin_match = 1'b0;

    int sender_idle_pct = 0;
    int ready_stall_pct = 0;
    int items_sent = 0;
    int fail_count = 0;
    int cycle_count = 0;

    logic [PAGE_W-1:0] page_w = PAGE_RESET;
    logic [PAGE_W-1:0] page_h = PAGE_RESET;
    logic [THR_W-1:0]  ratio_thr = THR_RESET;
    t_box              ref_boxes [TABLE_DEPTH];
    int                ref_count = 0;
    t_answer           pending_answers [$];

    box_min_area_overlap_match u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_corner_x0 (i_corner_x0),
        .i_corner_y0 (i_corner_y0),
        .i_corner_x1 (i_corner_x1),
        .i_corner_y1 (i_corner_y1),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_box_valid (o_box_valid),
        .o_is_match  (o_is_match)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit in_unit(input longint c);
        return c >= 0 && c <= longint'(ONE_Q16);
    endfunction

    function automatic bit normalize_box(input logic [COORD_W-1:0] x0r, y0r, x1r, y1r,
                                         output t_box b);
        longint x0, y0, x1, y1, t;
        x0 = longint'(signed'(x0r));
        y0 = longint'(signed'(y0r));
        x1 = longint'(signed'(x1r));
        y1 = longint'(signed'(y1r));
        if (in_unit(x0) && in_unit(y0) && in_unit(x1) && in_unit(y1)) begin
            x0 = x0 * longint'(page_w);
            x1 = x1 * longint'(page_w);
            y0 = y0 * longint'(page_h);
            y1 = y1 * longint'(page_h);
        end
        if (x1 < x0) begin
            t = x0;
            x0 = x1;
            x1 = t;
        end
        if (y1 < y0) begin
            t = y0;
            y0 = y1;
            y1 = t;
        end
        b = '{x0, y0, x1, y1};
        return (x1 > x0) && (y1 > y0);
    endfunction

    function automatic logic [AREA_W-1:0] box_area(input t_box b);
        logic [AREA_W-1:0] w, h;
        w = b.hi_x - b.lo_x;
        h = b.hi_y - b.lo_y;
        return w * h;
    endfunction

    // intersection * 1.0 >= threshold * smaller area, exact in 128 bits
    function automatic bit box_hits(input t_box q, input t_box r);
        t_box              overlap;
        logic [AREA_W-1:0] inter, qa, ra, smaller;
        logic [127:0]      lhs, rhs;
        overlap.lo_x = (q.lo_x > r.lo_x) ? q.lo_x : r.lo_x;
        overlap.lo_y = (q.lo_y > r.lo_y) ? q.lo_y : r.lo_y;
        overlap.hi_x = (q.hi_x < r.hi_x) ? q.hi_x : r.hi_x;
        overlap.hi_y = (q.hi_y < r.hi_y) ? q.hi_y : r.hi_y;
        inter = '0;
        if (overlap.hi_x > overlap.lo_x && overlap.hi_y > overlap.lo_y)
            inter = box_area(overlap);
        qa = box_area(q);
        ra = box_area(r);
        smaller = (ra < qa) ? ra : qa;
        lhs = {48'h0, inter, 16'h0};
        rhs = 128'(smaller) * 128'(ratio_thr);
        return lhs >= rhs;
    endfunction

    // updates the box table; returns 1 when the request produces an answer
    function automatic bit match_request(input logic [OP_W-1:0] op,
                                         input logic [COORD_W-1:0] x0, y0, x1, y1,
                                         output t_answer ans);
        t_box b;
        bit   ok;
        ans = '0;
        if (op == OP_CLEAR) begin
            ref_count = 0;
            return 1'b0;
        end
        if (op != OP_LOAD && op != OP_QUERY)
            return 1'b0;
        ok = normalize_box(x0, y0, x1, y1, b);
        if (op == OP_LOAD) begin
            if (ok && ref_count < TABLE_DEPTH) begin
                ref_boxes[ref_count] = b;
                ref_count++;
            end
            return 1'b0;
        end
        ans.box_valid = ok;
        if (ok) begin
            for (int i = 0; i < ref_count; i++)
                if (box_hits(b, ref_boxes[i]))
                    ans.is_match = 1'b1;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_answer want;
        t_answer pred;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_answers.size() == 0) begin
                    $error("unexpected answer: box_valid %0b is_match %0b",
                           o_box_valid, o_is_match);
                    fail_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (o_box_valid !== want.box_valid) begin
                        $error("box_valid: expected %0b, got %0b", want.box_valid, o_box_valid);
                        fail_count++;
                    end
                    if (o_is_match !== want.is_match) begin
                        $error("is_match: expected %0b, got %0b", want.is_match, o_is_match);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAGE_WIDTH:  page_w = i_cfg_data[PAGE_W-1:0];
                    CFG_PAGE_HEIGHT: page_h = i_cfg_data[PAGE_W-1:0];
                    CFG_THRESHOLD:   ratio_thr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                if (match_request(i_operation, i_corner_x0, i_corner_y0, i_corner_x1,
                                  i_corner_y1, pred)) begin
                    if (pin_row)
                        pred = '{pin_valid, pin_match};
                    pending_answers.push_back(pred);
                end
            end
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [COORD_W-1:0] x0, y0, x1, y1,
                                input logic pin, input logic pv, input logic pm);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_corner_x0 <= x0;
        i_corner_y0 <= y0;
        i_corner_x1 <= x1;
        i_corner_y1 <= y1;
        pin_row     <= pin;
        pin_valid   <= pv;
        pin_match   <= pm;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // hold off until every answer is in and the block has settled
    task automatic drain_requests();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= THR_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input t_coord_kind kind);
        case (kind)
            K_GRID:  return {16'($urandom_range(0, 63)),
                             ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'h0};
            K_UNIT:  return COORD_W'($urandom_range(0, 65536));
            K_FULL:  return COORD_W'($urandom);
            default: return EDGE_VALUES[$urandom_range(0, 7)];
        endcase
    endfunction

    task automatic send_random(input logic [OP_W-1:0] op);
        logic [COORD_W-1:0] c [4];
        t_coord_kind        kind;
        int                 pick;
        pick = $urandom_range(0, 99);
        kind = (pick < 45) ? K_GRID : (pick < 80) ? K_UNIT : (pick < 90) ? K_FULL : K_EDGE;
        foreach (c[i])
            c[i] = pick_coord(kind);
        if ($urandom_range(0, 19) == 0)
            c[2] = c[0];
        else if ($urandom_range(0, 19) == 0)
            c[3] = c[1];
        if (op != OP_UNUSED)
            items_sent++;
        send_request(op, c[0], c[1], c[2], c[3], 1'b0, 1'b0, 1'b0);
    endtask

    // optional clear, a run of loads, then queries with a little noise
    task automatic run_sequence();
        int n_load;
        int n_query;
        if ($urandom_range(0, 2) == 0)
            send_random(OP_CLEAR);
        n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 5);
        repeat (n_load) send_random(OP_LOAD);
        n_query = $urandom_range(1, 6);
        repeat (n_query) begin
            if ($urandom_range(0, 15) == 0)
                send_random(OP_UNUSED);
            send_random(($urandom_range(0, 9) == 0) ? OP_LOAD : OP_QUERY);
        end
    endtask

    initial begin : stimulus
        int w, h, thr;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: page 1 x 1, threshold one half
        foreach (DIRECTED[r])
            send_request(DIRECTED[r].op, DIRECTED[r].x0, DIRECTED[r].y0, DIRECTED[r].x1,
                         DIRECTED[r].y1, DIRECTED[r].pin, DIRECTED[r].pin_valid,
                         DIRECTED[r].pin_match);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_requests();
            w   = (PH_WIDTH[p] < 0) ? $urandom_range(2, 200) : PH_WIDTH[p];
            h   = (PH_HEIGHT[p] < 0) ? $urandom_range(2, 200) : PH_HEIGHT[p];
            thr = (PH_THR[p] < 0) ? $urandom_range(0, 65536) : PH_THR[p];
            write_reg(CFG_PAGE_WIDTH, w);
            write_reg(CFG_PAGE_HEIGHT, h);
            write_reg(CFG_THRESHOLD, thr);
            sender_idle_pct = PH_SEND[p];
            ready_stall_pct = PH_STALL[p];
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                run_sequence();
        end

        drain_requests();
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
